FILE: rtl/bpa_pkg.sv
// shared types and codes of the bitmap page allocator
package bpa_pkg;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BAD     = 2'd2
  } status_t;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef enum logic {
    REG_USABLE_PAGES = 1'b0,
    REG_BASE_PHASE   = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_FETCH,
    S_SCAN,
    S_WRD,
    S_WMOD,
    S_DONE
  } state_t;

  localparam int COUNT_W = 13;
  localparam int PAGE_W  = 12;

endpackage

FILE: rtl/bitmap_page_allocator.sv
// bitmap page allocator, first fit, one used bit per page in a word memory
// after reset a clearing pass writes all MAP_WORDS words, no input taken
// free: a read and a write-back per map word touched; zero-count or rejected request goes to the result
// allocate: a bit-serial remainder of the base phase, then one page per cycle of scan with a
//   fetch per map word and a closing step when no run fits, then a read and a write-back
//   per word of the written run; one request at a time, the page scan sets the rate
module bitmap_page_allocator #(
  parameter int MAP_WORDS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // num_pages[12:0], align_pages[25:13], page_index[37:26]
  input  logic [0:0]  s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // start_page[11:0]
  output logic [1:0]  m_axis_tuser,  // status
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  import bpa_pkg::*;

  localparam int CAP = MAP_WORDS * 64;
  localparam int PW  = ($clog2(CAP + 1) > COUNT_W) ? $clog2(CAP + 1) : COUNT_W;
  localparam int EW  = PW + 1;
  localparam int WAW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  logic [63:0] mem [MAP_WORDS];
  logic [63:0] rd_data;
  logic        mem_we;
  logic [63:0] mem_wdata;

  state_t state, state_next;

  logic [COUNT_W-1:0] usable_pages;
  logic [PAGE_W-1:0]  base_phase;

  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] align;
  logic [3:0]         mod_cnt;
  logic [COUNT_W-1:0] ph;
  logic [PW-1:0]      p;
  logic               cand;
  logic [PW-1:0]      cand_s;
  logic [COUNT_W-1:0] run;
  logic [PW-1:0]      lo;
  logic [PW-1:0]      hi;
  logic               op_clear;
  logic [WAW-1:0]     waddr;
  status_t            res_status;
  logic [PAGE_W-1:0]  res_start;
  logic               out_valid;
  logic [1:0]         out_status;
  logic [PAGE_W-1:0]  out_start;

  logic [PW-1:0]      limit;
  logic               in_xfer;
  logic [COUNT_W-1:0] in_count;
  logic [COUNT_W-1:0] in_align;
  logic [PAGE_W-1:0]  in_index;
  logic [EW-1:0]      free_end;
  logic [EW-1:0]      limit_e;
  logic [COUNT_W-1:0] trial;
  logic [COUNT_W-1:0] rem_next;
  logic               page_busy;
  logic               found;
  logic [WAW-1:0]     lo_w;
  logic [WAW-1:0]     hi_w;
  logic [5:0]         mask_a;
  logic [5:0]         mask_b;
  logic [63:0]        mask;
  logic               out_load;

  assign limit = ({{(PW-COUNT_W){1'b0}}, usable_pages} > PW'(CAP)) ? PW'(CAP)
               : {{(PW-COUNT_W){1'b0}}, usable_pages};
  assign limit_e  = {1'b0, limit};
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign in_count = s_axis_tdata[12:0];
  assign in_align = s_axis_tdata[25:13];
  assign in_index = s_axis_tdata[37:26];
  assign free_end = {{(EW-PAGE_W){1'b0}}, in_index} + {{(EW-COUNT_W){1'b0}}, in_count};

  assign trial    = {ph[PAGE_W-1:0], base_phase[mod_cnt]};
  assign rem_next = (trial >= align) ? trial - align : trial;

  assign page_busy = rd_data[~p[5:0]];
  assign found = !page_busy && ((cand && (run + 1'b1 == count))
               || (!cand && (ph == '0) && (count == COUNT_W'(1))));

  assign lo_w   = lo[WAW+5:6];
  assign hi_w   = hi[WAW+5:6];
  assign mask_a = (waddr == lo_w) ? lo[5:0] : 6'd0;
  assign mask_b = (waddr == hi_w) ? hi[5:0] : 6'd63;
  assign mask   = ({64{1'b1}} >> mask_a) & ({64{1'b1}} << (6'd63 - mask_b));

  assign out_load = (state == S_DONE) && (!out_valid || m_axis_tready);

  // map memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= mem_wdata;
    end
    rd_data <= mem[waddr];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (waddr == WAW'(MAP_WORDS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_xfer) begin
          if (s_axis_tuser[0] == ACT_FREE) begin
            if ({{(PW-PAGE_W){1'b0}}, in_index} >= limit || in_count == '0) begin
              state_next = S_DONE;
            end else begin
              state_next = S_WRD;
            end
          end else if (in_count == '0) begin
            state_next = S_DONE;
          end else begin
            state_next = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (mod_cnt == 4'd0) state_next = S_FETCH;
      end
      S_FETCH: state_next = S_SCAN;
      S_SCAN: begin
        if (p >= limit) begin
          state_next = S_DONE;
        end else if (found) begin
          state_next = S_WRD;
        end else if (p[5:0] == 6'd63) begin
          state_next = S_FETCH;
        end
      end
      S_WRD: state_next = S_WMOD;
      S_WMOD: begin
        state_next = (waddr == hi_w) ? S_DONE : S_WRD;
      end
      S_DONE: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    s_axis_tready = 1'b0;
    mem_we        = 1'b0;
    mem_wdata     = '0;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_IDLE: begin
        s_axis_tready = 1'b1;
      end
      S_WMOD: begin
        mem_we    = 1'b1;
        mem_wdata = op_clear ? (rd_data & ~mask) : (rd_data | mask);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      waddr        <= '0;
      usable_pages <= COUNT_W'(4096);
      base_phase   <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_USABLE_PAGES: usable_pages <= cfg_data;
          REG_BASE_PHASE:   base_phase   <= cfg_data[PAGE_W-1:0];
          default:          base_phase   <= base_phase;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: waddr <= waddr + 1'b1;
        S_IDLE: begin
          if (in_xfer) begin
            if (s_axis_tuser[0] == ACT_FREE) begin
              waddr <= WAW'({{(PW-PAGE_W){1'b0}}, in_index} >> 6);
            end else begin
              waddr <= '0;
            end
          end
        end
        S_SCAN: begin
          if (p < limit && found) begin
            waddr <= (cand ? cand_s[WAW+5:6] : p[WAW+5:6]);
          end else if (p < limit && p[5:0] == 6'd63) begin
            waddr <= waddr + 1'b1;
          end
        end
        S_WMOD: begin
          if (waddr != hi_w) waddr <= waddr + 1'b1;
        end
        default: waddr <= waddr;
      endcase
    end
  end

  // operation datapath
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= res_status;
      out_start  <= res_start;
    end
    case (state)
      S_IDLE: begin
        count     <= in_count;
        align     <= (in_align == '0) ? COUNT_W'(1) : in_align;
        mod_cnt   <= 4'(PAGE_W - 1);
        ph        <= '0;
        p         <= '0;
        cand      <= 1'b0;
        run       <= '0;
        op_clear  <= 1'b1;
        res_start <= '0;
        lo        <= {{(PW-PAGE_W){1'b0}}, in_index};
        if (free_end > limit_e) hi <= limit - 1'b1;
        else                    hi <= free_end[PW-1:0] - 1'b1;
        if (s_axis_tuser[0] == ACT_FREE) begin
          if ({{(PW-PAGE_W){1'b0}}, in_index} >= limit) res_status <= ST_NOSPACE;
          else if (free_end > limit_e)                 res_status <= ST_BAD;
          else                                         res_status <= ST_OK;
        end else begin
          res_status <= (in_count == '0) ? ST_BAD : ST_OK;
        end
      end
      S_MOD: begin
        ph      <= rem_next;
        mod_cnt <= mod_cnt - 1'b1;
      end
      S_SCAN: begin
        if (p >= limit) begin
          res_status <= ST_NOSPACE;
        end else if (found) begin
          op_clear   <= 1'b0;
          lo         <= cand ? cand_s : p;
          hi         <= p;
          res_status <= ST_OK;
          res_start  <= cand ? cand_s[PAGE_W-1:0] : p[PAGE_W-1:0];
        end else begin
          p  <= p + 1'b1;
          ph <= (ph + 1'b1 == align) ? '0 : ph + 1'b1;
          if (page_busy) begin
            cand <= 1'b0;
          end else if (cand) begin
            run <= run + 1'b1;
          end else if (ph == '0) begin
            cand   <= 1'b1;
            cand_s <= p;
            run    <= COUNT_W'(1);
          end
        end
      end
      default: begin
        p <= p;
      end
    endcase
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = {4'd0, out_start};

endmodule

FILE: rtl/bpa_checker.sv
// port-level checks of the bitmap page allocator, bound to the top level
module bpa_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import bpa_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tuser)
      && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser == ST_OK || m_axis_tuser == ST_NOSPACE
      || m_axis_tuser == ST_BAD)
    else $error("status code out of range");

  a_start_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata == 16'd0)
    else $error("start page set on a failed request");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && !s_axis_tready)
    else $error("handshake active right after reset");

  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second transfer taken while busy");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/sv/testbench.sv
// self-checking testbench for bitmap_page_allocator with a page-map predictor
`timescale 1ns / 100ps

class page_scoreboard;
  bit [4095:0] used;
  int unsigned usable_pages;
  int unsigned base_phase;
  bit [13:0] pending[$];
  int errors;

  function void reset_state();
    used = '0;
    usable_pages = 4096;
    base_phase = 0;
    pending.delete();
    errors = 0;
  endfunction

  function void set_reg(bpa_pkg::cfg_reg_t idx, int unsigned value);
    if (idx == bpa_pkg::REG_USABLE_PAGES) begin
      usable_pages = value & 13'h1fff;
    end else begin
      base_phase = value & 12'hfff;
    end
  endfunction

  function void note_request(bpa_pkg::action_t act, int unsigned count,
                             int unsigned align, int unsigned first);
    int unsigned limit;
    int unsigned s;
    int unsigned q;
    int unsigned rem;
    int unsigned stop;
    bit fits;
    bpa_pkg::status_t st;
    bit [11:0] start;
    limit = (usable_pages < 4096) ? usable_pages : 4096;
    st = bpa_pkg::ST_OK;
    start = '0;
    if (act == bpa_pkg::ACT_ALLOC) begin
      if (count == 0) begin
        st = bpa_pkg::ST_BAD;
      end else begin
        if (align == 0) align = 1;
        st = bpa_pkg::ST_NOSPACE;
        s = 0;
        while (s + count <= limit) begin
          rem = (base_phase + s) % align;
          if (rem != 0) begin
            s = s + align - rem;
            continue;
          end
          fits = 1;
          for (q = s; q < s + count; q++) begin
            if (used[q]) begin
              fits = 0;
              break;
            end
          end
          if (fits) begin
            for (q = s; q < s + count; q++) used[q] = 1'b1;
            st = bpa_pkg::ST_OK;
            start = s[11:0];
            break;
          end
          s = q + 1;
        end
      end
    end else begin
      stop = first + count;
      if (first >= limit) begin
        st = bpa_pkg::ST_NOSPACE;
      end else begin
        if (stop > limit) begin
          stop = limit;
          st = bpa_pkg::ST_BAD;
        end
        for (q = first; q < stop; q++) used[q] = 1'b0;
      end
    end
    pending.push_back({st, start});
  endfunction

  function void check_reply(logic [1:0] st, logic [11:0] start);
    bit [13:0] exp;
    if (pending.size() == 0) begin
      $error("unexpected result status %0d start_page %0d", st, start);
      errors++;
      return;
    end
    exp = pending.pop_front();
    if (st !== exp[13:12]) begin
      $error("status expected %0d actual %0d", exp[13:12], st);
      errors++;
    end
    if (start !== exp[11:0]) begin
      $error("start_page expected %0d actual %0d", exp[11:0], start);
      errors++;
    end
  endfunction
endclass

module testbench;
  import bpa_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;

  page_scoreboard sb;
  int idle_cycles = 0;
  int replies = 0;
  int hold_left = 0;
  bit hold_done = 0;

  bitmap_page_allocator DUT (.*);

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  // receiver with random stalls and one long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_reply(m_axis_tuser, m_axis_tdata[11:0]);
        replies++;
      end
      if (!hold_done && replies == 300) begin
        hold_done = 1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 9) < 3);
        if ($urandom_range(0, 99) < 3) hold_left = $urandom_range(10, 50);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 40000) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  task automatic send_item(action_t act, int unsigned count, int unsigned align,
                           int unsigned first);
    int gap;
    s_axis_tdata <= {2'b00, first[11:0], align[12:0], count[12:0]};
    s_axis_tuser <= act;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(act, count, align, first);
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int unsigned value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[12:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic random_items(int n, int unsigned lim);
    int unsigned count;
    int unsigned align;
    int unsigned first;
    int unsigned small_max;
    int r;
    small_max = (lim < 16) ? ((lim == 0) ? 1 : lim) : 16;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 3) count = $urandom_range(0, 4096);
      else if (r < 6) count = 0;
      else count = $urandom_range(1, small_max);
      r = $urandom_range(0, 99);
      if (r < 5) align = $urandom_range(0, 4096);
      else align = $urandom_range(0, 9);
      r = $urandom_range(0, 99);
      if (r < 5) first = $urandom_range(0, 4095);
      else first = $urandom_range(0, (lim > 4095) ? 4095 : lim);
      if ($urandom_range(0, 99) < 58) send_item(ACT_ALLOC, count, align, first);
      else send_item(ACT_FREE, count, align, first);
    end
  endtask

  initial begin
    int unsigned lims[8] = '{1, 200, 4096, 130, 64, 4096, 513, 77};
    int unsigned phases[8] = '{0, 3, 4095, 7, 1, 2730, 1365, 4095};
    sb = new();
    sb.reset_state();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_item(ACT_ALLOC, 0, 0, 4095);
    send_item(ACT_ALLOC, 1, 0, 0);
    send_item(ACT_ALLOC, 4096, 1, 0);
    send_item(ACT_ALLOC, 5, 4096, 0);
    send_item(ACT_FREE, 1, 0, 0);
    send_item(ACT_FREE, 0, 0, 0);
    send_item(ACT_FREE, 4096, 0, 4095);
    send_item(ACT_ALLOC, 4096, 8191, 0);
    send_item(ACT_ALLOC, 1, 1, 0);
    send_item(ACT_FREE, 4096, 0, 0);
    send_item(ACT_FREE, 10, 0, 0);
    send_item(ACT_ALLOC, 3, 7, 0);
    send_item(ACT_ALLOC, 64, 64, 0);
    send_item(ACT_ALLOC, 100, 4096, 0);
    send_item(ACT_ALLOC, 2, 3, 0);
    send_item(ACT_FREE, 4095, 0, 1);
    drain();
    write_reg(REG_USABLE_PAGES, 0);
    write_reg(REG_BASE_PHASE, 4095);
    send_item(ACT_ALLOC, 1, 0, 0);
    send_item(ACT_ALLOC, 0, 0, 0);
    send_item(ACT_FREE, 1, 0, 0);
    send_item(ACT_FREE, 0, 0, 4095);
    drain();

    for (int p = 0; p < 8; p++) begin
      write_reg(REG_USABLE_PAGES, lims[p]);
      write_reg(REG_BASE_PHASE, phases[p]);
      random_items((lims[p] == 4096) ? 120 : 240, lims[p]);
      drain();
    end

    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
